/* rtl/core/bpa_pkg.sv */
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int PAGE_COUNT_DEF = 65536;
    localparam int TOP_ORDER_DEF  = 14;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 27;
    localparam int ORD_W  = 5;
    localparam int PT_W   = 6;
    localparam int CAP_W  = 40;
    localparam int CFG_IDX_W = 1;

    localparam logic [PT_W-1:0] PT_NOT_HEAD = 6'h1F;
    localparam logic            PT_FREE     = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_BLOCKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE       = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic [SIZE_W-1:0]  size_bytes;
        logic [ADDR_W-1:0]  address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  block_address;
        logic [3:0]         block_order;
        logic [1:0]         status;
    } rsp_t;

endpackage

/* rtl/core/buddy_page_allocator_core.sv */
`timescale 1ns / 1ps
// Binary buddy page allocator, one command at a time.
// Command channel: request word taken when start is high and busy is low;
//   request.cmd selects allocate (size_bytes) or free (address).
// Result channel: one result word per command on result, marked by done for
//   exactly one cycle; the receiver cannot stall it.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 is
//   the top block count and re-runs the initialisation; index 1 is the base.
//   Write only while idle.
// Sequence: allocate raises the order from the request order k until the block
//   size covers the request, searches up to the first order j with a free block,
//   then splits down one order per step, pushing each buddy that lies in range;
//   free checks the address and the page table entry, then merges one order per
//   step and ends with a push of the merged block. The sequencer walks one order
//   per step, with one read and one write per page memory each cycle.
// Reset: after reset, and after a top block count write, a clearing pass
//   sweeps every page table entry, then each top block is linked in through
//   S_INIT, S_PUSH1 and S_PUSH2; busy stays high throughout.

module buddy_page_allocator_core #(
    parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
    parameter int TOP_ORDER  = bpa_pkg::TOP_ORDER_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  bpa_pkg::req_t                   request,
    output logic                            done,
    output bpa_pkg::rsp_t                   result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]      cfg_data
);

    localparam int IW  = $clog2(PAGE_COUNT);
    localparam int LW  = IW + 1;
    localparam int HN  = TOP_ORDER + 1;
    localparam int HW  = (HN > 1) ? $clog2(HN) : 1;
    localparam int XW  = ((IW > TOP_ORDER) ? IW : TOP_ORDER) + 1;
    localparam int LIM = PAGE_COUNT >> TOP_ORDER;
    localparam int OW  = bpa_pkg::ORD_W;
    localparam int PW  = bpa_pkg::PT_W;

    localparam logic [LW-1:0] NIL   = LW'(PAGE_COUNT);
    localparam logic [OW-1:0] TOP_O = OW'(TOP_ORDER);
    localparam logic [3:0]    LIM_C = (LIM > 7) ? 4'd7 : 4'(LIM);

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_CLR    = 15'h0002,
        S_INIT   = 15'h0004,
        S_KSRCH  = 15'h0008,
        S_JSRCH  = 15'h0010,
        S_AREM   = 15'h0020,
        S_SPLIT  = 15'h0040,
        S_FCHK   = 15'h0080,
        S_FCHK3  = 15'h0100,
        S_FMERGE = 15'h0200,
        S_FMCHK  = 15'h0400,
        S_PUSH1  = 15'h0800,
        S_PUSH2  = 15'h1000,
        S_SPARE0 = 15'h2000,
        S_SPARE1 = 15'h4000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [OW-1:0]    k_reg, k_next, ord_reg, ord_next, pord_reg, pord_next;
    logic [bpa_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [IW-1:0]    cur_reg, cur_next, pidx_reg, pidx_next, clr_reg, clr_next;
    logic [LW-1:0]    ph_reg, ph_next;
    logic [2:0]       n_reg, n_next, top_reg;
    logic [bpa_pkg::ADDR_W-1:0] base_reg;
    bpa_pkg::req_t    req_reg, req_next;
    bpa_pkg::rsp_t    res_reg, res_next;
    logic             done_reg, done_next;

    logic [LW-1:0]    head_reg [HN];
    logic [HW-1:0]    head_ri, head_wi;
    logic [LW-1:0]    head_rd, head_wd;
    logic             head_we, head_clr;

    logic [PW-1:0]    pt_mem [PAGE_COUNT];
    logic [LW-1:0]    nl_mem [PAGE_COUNT];
    logic [LW-1:0]    pl_mem [PAGE_COUNT];
    logic             pt_we, nl_we, pl_we;
    logic [IW-1:0]    pt_wa, nl_wa, pl_wa, pt_ra, nl_ra, pl_ra;
    logic [PW-1:0]    pt_wd, pt_q;
    logic [LW-1:0]    nl_wd, pl_wd, nl_q, pl_q;

    logic             cfg_wr, au_bad;
    logic [IW-1:0]    au_page;
    logic [bpa_pkg::ADDR_W-1:0] au_addr;
    logic [XW-1:0]    bud;

    bpa_addr_unit #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_addr (
        .base      (base_reg),
        .address   (req_reg.address),
        .page_idx  (cur_reg),
        .bad       (au_bad),
        .page      (au_page),
        .page_addr (au_addr)
    );

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign head_rd   = head_reg[head_ri];

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        k_next     = k_reg;
        ord_next   = ord_reg;
        pord_next  = pord_reg;
        cap_next   = cap_reg;
        cur_next   = cur_reg;
        pidx_next  = pidx_reg;
        clr_next   = clr_reg;
        ph_next    = ph_reg;
        n_next     = n_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        head_ri    = ord_reg[HW-1:0];
        head_we    = 1'b0;
        head_wi    = ord_reg[HW-1:0];
        head_wd    = NIL;
        head_clr   = 1'b0;
        pt_we = 1'b0; pt_wa = pidx_reg; pt_wd = bpa_pkg::PT_NOT_HEAD; pt_ra = cur_reg;
        nl_we = 1'b0; nl_wa = pidx_reg; nl_wd = NIL; nl_ra = cur_reg;
        pl_we = 1'b0; pl_wa = pidx_reg; pl_wd = NIL; pl_ra = cur_reg;
        bud = XW'(cur_reg) ^ (XW'(1) << ord_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    if (request.cmd == bpa_pkg::CMD_ALLOC)
                    begin
                        k_next     = '0;
                        cap_next   = bpa_pkg::CAP_W'(PAGE_BYTES);
                        state_next = S_KSRCH;
                    end
                    else
                    begin
                        state_next = S_FCHK;
                    end
                end
            end
            S_CLR:
            begin
                pt_we = 1'b1;
                pt_wa = clr_reg;
                pt_wd = bpa_pkg::PT_NOT_HEAD;
                if (clr_reg == IW'(PAGE_COUNT - 1))
                begin
                    n_next     = ({1'b0, top_reg} > LIM_C) ? LIM_C[2:0] : top_reg;
                    state_next = S_INIT;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_INIT:
            begin
                head_ri = TOP_O[HW-1:0];
                if (n_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pord_next  = TOP_O;
                    pidx_next  = IW'(n_reg - 3'd1) << TOP_ORDER;
                    ph_next    = head_rd;
                    ret_next   = S_INIT;
                    n_next     = n_reg - 3'd1;
                    state_next = S_PUSH1;
                end
            end
            S_KSRCH:
            begin
                if (k_reg > TOP_O)
                begin
                    res_next   = '{block_address: '0, block_order: '0,
                                   status: bpa_pkg::ST_OVERSIZE};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cap_reg < bpa_pkg::CAP_W'(req_reg.size_bytes))
                begin
                    k_next   = k_reg + 1'b1;
                    cap_next = cap_reg << 1;
                end
                else
                begin
                    ord_next   = k_reg;
                    state_next = S_JSRCH;
                end
            end
            S_JSRCH:
            begin
                if (ord_reg > TOP_O)
                begin
                    res_next   = '{block_address: '0, block_order: '0,
                                   status: bpa_pkg::ST_NO_MEM};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (head_rd == NIL)
                begin
                    ord_next = ord_reg + 1'b1;
                end
                else
                begin
                    cur_next   = head_rd[IW-1:0];
                    nl_ra      = head_rd[IW-1:0];
                    state_next = S_AREM;
                end
            end
            S_AREM:
            begin
                head_we = 1'b1;
                head_wd = nl_q;
                if (nl_q != NIL)
                begin
                    pl_we = 1'b1;
                    pl_wa = nl_q[IW-1:0];
                    pl_wd = NIL;
                end
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                head_ri = HW'(ord_reg - 1'b1);
                bud     = XW'(cur_reg) ^ (XW'(1) << (ord_reg - 1'b1));
                if (ord_reg > k_reg)
                begin
                    ord_next = ord_reg - 1'b1;
                    if (bud < XW'(PAGE_COUNT))
                    begin
                        pord_next  = ord_reg - 1'b1;
                        pidx_next  = bud[IW-1:0];
                        ph_next    = head_rd;
                        ret_next   = S_SPLIT;
                        state_next = S_PUSH1;
                    end
                end
                else
                begin
                    pt_we      = 1'b1;
                    pt_wa      = cur_reg;
                    pt_wd      = {1'b0, k_reg};
                    res_next   = '{block_address: au_addr, block_order: k_reg[3:0],
                                   status: bpa_pkg::ST_OK};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FCHK:
            begin
                if (au_bad)
                begin
                    res_next   = '{block_address: '0, block_order: '0,
                                   status: bpa_pkg::ST_BAD_FREE};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = au_page;
                    pt_ra      = au_page;
                    state_next = S_FCHK3;
                end
            end
            S_FCHK3:
            begin
                if (pt_q[PW-1] || (pt_q[OW-1:0] > TOP_O))
                begin
                    res_next   = '{block_address: '0, block_order: '0,
                                   status: bpa_pkg::ST_BAD_FREE};
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    res_next   = '{block_address: au_addr, block_order: pt_q[3:0],
                                   status: bpa_pkg::ST_OK};
                    ord_next   = pt_q[OW-1:0];
                    state_next = S_FMERGE;
                end
            end
            S_FMERGE:
            begin
                if (ord_reg < TOP_O && bud < XW'(PAGE_COUNT))
                begin
                    pt_ra      = bud[IW-1:0];
                    nl_ra      = bud[IW-1:0];
                    pl_ra      = bud[IW-1:0];
                    pidx_next  = bud[IW-1:0];
                    state_next = S_FMCHK;
                end
                else
                begin
                    pord_next  = ord_reg;
                    pidx_next  = cur_reg;
                    ph_next    = head_rd;
                    ret_next   = S_IDLE;
                    state_next = S_PUSH1;
                end
            end
            S_FMCHK:
            begin
                if (pt_q != {bpa_pkg::PT_FREE, ord_reg})
                begin
                    pord_next  = ord_reg;
                    pidx_next  = cur_reg;
                    ph_next    = head_rd;
                    ret_next   = S_IDLE;
                    state_next = S_PUSH1;
                end
                else
                begin
                    if (pl_q != NIL)
                    begin
                        nl_we = 1'b1;
                        nl_wa = pl_q[IW-1:0];
                        nl_wd = nl_q;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wd = nl_q;
                    end
                    if (nl_q != NIL)
                    begin
                        pl_we = 1'b1;
                        pl_wa = nl_q[IW-1:0];
                        pl_wd = pl_q;
                    end
                    // lower index survives; the upper head is retired
                    pt_we      = 1'b1;
                    pt_wa      = (pidx_reg > cur_reg) ? pidx_reg : cur_reg;
                    pt_wd      = bpa_pkg::PT_NOT_HEAD;
                    cur_next   = (pidx_reg < cur_reg) ? pidx_reg : cur_reg;
                    ord_next   = ord_reg + 1'b1;
                    state_next = S_FMERGE;
                end
            end
            S_PUSH1:
            begin
                nl_we = 1'b1;
                nl_wd = ph_reg;
                pl_we = 1'b1;
                pl_wd = NIL;
                pt_we = 1'b1;
                pt_wd = {bpa_pkg::PT_FREE, pord_reg};
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                if (ph_reg != NIL)
                begin
                    pl_we = 1'b1;
                    pl_wa = ph_reg[IW-1:0];
                    pl_wd = LW'(pidx_reg);
                end
                head_we    = 1'b1;
                head_wi    = pord_reg[HW-1:0];
                head_wd    = LW'(pidx_reg);
                state_next = ret_reg;
                if (ret_reg == S_IDLE)
                begin
                    done_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr && cfg_index == bpa_pkg::CFG_TOP_BLOCKS)
        begin
            state_next = S_CLR;
            clr_next   = '0;
            head_clr   = 1'b1;
            head_we    = 1'b0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_IDLE;
            clr_reg   <= '0;
            n_reg     <= '0;
            done_reg  <= 1'b0;
            top_reg   <= 3'd4;
            base_reg  <= '0;
            for (int i = 0; i < HN; i++)
            begin
                head_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            clr_reg   <= clr_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
            if (cfg_wr && cfg_index == bpa_pkg::CFG_TOP_BLOCKS)
            begin
                top_reg <= cfg_data[2:0];
            end
            if (cfg_wr && cfg_index == bpa_pkg::CFG_BASE)
            begin
                base_reg <= cfg_data;
            end
            if (head_clr)
            begin
                for (int i = 0; i < HN; i++)
                begin
                    head_reg[i] <= NIL;
                end
            end
            else if (head_we)
            begin
                head_reg[head_wi] <= head_wd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        ord_reg  <= ord_next;
        pord_reg <= pord_next;
        cap_reg  <= cap_next;
        cur_reg  <= cur_next;
        pidx_reg <= pidx_next;
        ph_reg   <= ph_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_wa] <= pt_wd;
        end
        pt_q <= pt_mem[pt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            nl_mem[nl_wa] <= nl_wd;
        end
        nl_q <= nl_mem[nl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pl_we)
        begin
            pl_mem[pl_wa] <= pl_wd;
        end
        pl_q <= pl_mem[pl_ra];
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != bpa_pkg::ST_OK |->
            result.block_address == '0 && result.block_order == '0)
        else $error("error result carries a block");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cfg_valid |=> busy)
        else $error("command taken without going busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still working");

endmodule

/* rtl/core/bpa_addr_unit.sv */
`timescale 1ns / 1ps

module bpa_addr_unit #(
    parameter int PAGE_COUNT = bpa_pkg::PAGE_COUNT_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic [bpa_pkg::ADDR_W-1:0]     base,
    input  logic [bpa_pkg::ADDR_W-1:0]     address,
    input  logic [$clog2(PAGE_COUNT)-1:0]  page_idx,
    output logic                           bad,
    output logic [$clog2(PAGE_COUNT)-1:0]  page,
    output logic [bpa_pkg::ADDR_W-1:0]     page_addr
);

    localparam int IW  = $clog2(PAGE_COUNT);
    localparam int PBS = $clog2(PAGE_BYTES);

    logic [bpa_pkg::ADDR_W:0] off;

    // byte offset from base; bit 48 is the borrow
    assign off = {1'b0, address} - {1'b0, base};
    assign bad = off[bpa_pkg::ADDR_W]
               | (off[PBS-1:0] != '0)
               | ((off[bpa_pkg::ADDR_W-1:0] >> PBS) >= bpa_pkg::ADDR_W'(PAGE_COUNT));
    assign page = off[PBS +: IW];
    assign page_addr = base + (bpa_pkg::ADDR_W'(page_idx) << PBS);

endmodule
